// File: hdl/background_average_model_assert.svh
// Assertion macros for the background averaging block.
`ifndef BACKGROUND_AVERAGE_MODEL_ASSERT_SVH
`define BACKGROUND_AVERAGE_MODEL_ASSERT_SVH
`ifndef SYNTHESIS
`define BAM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define BAM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);
`else
`define BAM_ASSERT(lbl, prop, msg)
`define BAM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: hdl/bam_pkg.sv
package bam_pkg;

  localparam int CHAN_W     = 8;
  localparam int PIX_W      = 16;
  localparam int OP_W       = 2;
  localparam int NCHAN      = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;

  localparam logic [OP_W-1:0] OP_LEARN    = 2'd0;
  localparam logic [OP_W-1:0] OP_BUILD    = 2'd1;
  localparam logic [OP_W-1:0] OP_CLASSIFY = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_SCALE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_SCALE  = 1'd1;

  localparam logic [CFG_DATA_W-1:0] HIGH_SCALE_RST = 4'd7;
  localparam logic [CFG_DATA_W-1:0] LOW_SCALE_RST  = 4'd6;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [PIX_W-1:0]  pixel_index;
    logic [CHAN_W-1:0] chan_first;
    logic [CHAN_W-1:0] chan_second;
    logic [CHAN_W-1:0] chan_third;
    logic              frame_end;
  } in_t;

  typedef struct packed {
    logic             mask_out;
    logic [PIX_W-1:0] index_out;
  } out_t;

endpackage

// File: hdl/background_average_model.sv
// Channel  Handshake                 Payload
// in       in_valid_i / in_ready_o   in_data_i  (learn, build, classify)
// out      out_valid_o / out_ready_i out_data_o (classify result)
// cfg      cfg_we_i                  cfg_idx_i, cfg_data_i
//
// One transaction per cycle while in_ready_o is high; results pass through the
// bit-per-stage divider pipeline (one stage per quotient bit).
// After reset a sweep clears every address of the sum and difference stores;
// in_ready_o stays low meanwhile. Config writes are taken at any time.
// A stalled output freezes the whole pipeline; nothing is dropped.
`include "background_average_model_assert.svh"

module background_average_model #(
  parameter int PIXELS           = 65536,
  parameter int MAX_LEARN_FRAMES = 32,
  parameter int FRACTION_BITS    = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  bam_pkg::in_t                   in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output bam_pkg::out_t                  out_data_o,
  input  logic                           cfg_we_i,
  input  logic [bam_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bam_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import bam_pkg::*;

  localparam int ADDR_W = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam int SUM_W  = $clog2(255 * MAX_LEARN_FRAMES + 1);
  localparam int NW     = $clog2(MAX_LEARN_FRAMES + 1);
  localparam int DW     = SUM_W + FRACTION_BITS;
  localparam int MW     = DW + 1;
  localparam int PW     = MW + CFG_DATA_W;
  localparam int BW     = PW + 1;

  typedef struct packed {
    logic                           valid;
    logic [OP_W-1:0]                op;
    logic [PIX_W-1:0]               pix;
    logic                           rng;
    logic [NCHAN-1:0][CHAN_W-1:0]   chan;
  } meta_t;

  logic advance, in_fire;
  logic [CFG_DATA_W-1:0] hs_q, ls_q;
  logic clr_busy_q;
  logic [ADDR_W-1:0] clr_idx_q;
  logic [NW-1:0] frames_q;
  logic first_q;

  meta_t in_meta, p1_q, m_q, x_q;
  meta_t dv_q [DW];
  logic p1_fend_q;

  logic [ADDR_W-1:0] in_addr, p1_addr, m_addr, x_addr;

  logic [NCHAN-1:0][SUM_W-1:0]  sum_mem [PIXELS];
  logic [NCHAN-1:0][SUM_W-1:0]  diff_mem [PIXELS];
  logic [NCHAN-1:0][CHAN_W-1:0] prev_mem [PIXELS];
  logic [NCHAN-1:0][BW-1:0]     upr_mem [PIXELS];
  logic [NCHAN-1:0][BW-1:0]     lwr_mem [PIXELS];

  logic [NCHAN-1:0][SUM_W-1:0]  sum_rd_q, diff_rd_q, sum_byp_q, diff_byp_q;
  logic [NCHAN-1:0][CHAN_W-1:0] prev_rd_q, prev_byp_q;
  logic fwd_q;
  logic [NCHAN-1:0][SUM_W-1:0]  sum_cur, diff_cur, sum_new, diff_new;
  logic [NCHAN-1:0][CHAN_W-1:0] prev_cur;
  logic at_bound, lrn_op, lrn_wr;
  logic [NW-1:0] n_sel;

  logic [DW-1:0] qs [NCHAN];
  logic [DW-1:0] qd [NCHAN];
  logic [DW-1:0] mean_q [NCHAN];
  logic [PW-1:0] prh_q [NCHAN];
  logic [PW-1:0] prl_q [NCHAN];
  logic [NCHAN-1:0][BW-1:0] upr_q, lwr_q;
  logic [NCHAN-1:0][BW-1:0] upr_rd_q, lwr_rd_q, upr_byp_q, lwr_byp_q, upr_cur, lwr_cur;
  logic bfwd_q, bld_wr, hit;

  logic out_valid_q;
  out_t out_q;

  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = advance && !clr_busy_q;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    in_meta.valid   = in_fire;
    in_meta.op      = in_data_i.opcode;
    in_meta.pix     = in_data_i.pixel_index;
    in_meta.rng     = 32'(in_data_i.pixel_index) < 32'(PIXELS);
    in_meta.chan[0] = in_data_i.chan_first;
    in_meta.chan[1] = in_data_i.chan_second;
    in_meta.chan[2] = in_data_i.chan_third;
  end

  assign in_addr = ADDR_W'(in_data_i.pixel_index);
  assign p1_addr = ADDR_W'(p1_q.pix);
  assign m_addr  = ADDR_W'(m_q.pix);
  assign x_addr  = ADDR_W'(x_q.pix);

  // config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hs_q <= HIGH_SCALE_RST;
      ls_q <= LOW_SCALE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_HIGH_SCALE: hs_q <= cfg_data_i;
        CFG_LOW_SCALE:  ls_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // clearing sweep of the sum and difference stores
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_idx_q  <= '0;
    end else if (clr_busy_q) begin
      clr_idx_q <= clr_idx_q + 1'b1;
      if (clr_idx_q == ADDR_W'(PIXELS - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // stage P1: learn
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_q      <= '0;
      p1_fend_q <= 1'b0;
    end else if (advance) begin
      p1_q      <= in_meta;
      p1_fend_q <= in_data_i.frame_end;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      sum_rd_q  <= sum_mem[in_addr];
      diff_rd_q <= diff_mem[in_addr];
      prev_rd_q <= prev_mem[in_addr];
    end
  end

  assign at_bound = frames_q >= NW'(MAX_LEARN_FRAMES);
  assign lrn_op   = advance && p1_q.valid && (p1_q.op == OP_LEARN) && !at_bound;
  assign lrn_wr   = lrn_op && p1_q.rng;
  assign n_sel    = (frames_q == '0) ? NW'(1) : frames_q;

  always_comb begin
    sum_cur  = fwd_q ? sum_byp_q : sum_rd_q;
    diff_cur = fwd_q ? diff_byp_q : diff_rd_q;
    prev_cur = fwd_q ? prev_byp_q : prev_rd_q;
    for (int c = 0; c < NCHAN; c++) begin
      if (first_q) begin
        sum_new[c]  = sum_cur[c] + SUM_W'(p1_q.chan[c]);
        diff_new[c] = diff_cur[c] + SUM_W'((p1_q.chan[c] > prev_cur[c]) ?
                      (p1_q.chan[c] - prev_cur[c]) : (prev_cur[c] - p1_q.chan[c]));
      end else begin
        sum_new[c]  = sum_cur[c];
        diff_new[c] = diff_cur[c];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      sum_mem[clr_idx_q]  <= '0;
      diff_mem[clr_idx_q] <= '0;
    end else if (lrn_wr) begin
      sum_mem[p1_addr]  <= sum_new;
      diff_mem[p1_addr] <= diff_new;
      prev_mem[p1_addr] <= p1_q.chan;
    end
  end

  // same-edge write/read bypass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (advance) begin
      fwd_q <= lrn_wr && (p1_q.pix == in_data_i.pixel_index);
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      sum_byp_q  <= sum_new;
      diff_byp_q <= diff_new;
      prev_byp_q <= p1_q.chan;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_q <= '0;
      first_q  <= 1'b0;
    end else if (lrn_op && p1_fend_q) begin
      if (first_q) begin
        frames_q <= frames_q + 1'b1;
      end
      first_q <= 1'b1;
    end
  end

  // divider stages
  for (genvar c = 0; c < NCHAN; c++) begin : g_chan
    logic [DW-1:0] xs, xd;
    assign xs = DW'(sum_cur[c]) << FRACTION_BITS;
    assign xd = DW'(diff_cur[c]) << FRACTION_BITS;

    bam_div #(.DW(DW), .NW(NW)) u_div_sum (
      .clk_i (clk_i),
      .en_i  (advance),
      .x_i   (xs),
      .n_i   (n_sel),
      .q_o   (qs[c])
    );

    bam_div #(.DW(DW), .NW(NW)) u_div_diff (
      .clk_i (clk_i),
      .en_i  (advance),
      .x_i   (xd),
      .n_i   (n_sel),
      .q_o   (qd[c])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DW; k++) begin
        dv_q[k] <= '0;
      end
    end else if (advance) begin
      dv_q[0] <= p1_q;
      for (int k = 1; k < DW; k++) begin
        dv_q[k] <= dv_q[k-1];
      end
    end
  end

  // stage M: scale products
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_q <= '0;
    end else if (advance) begin
      m_q <= dv_q[DW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      for (int c = 0; c < NCHAN; c++) begin
        mean_q[c] <= qs[c];
        prh_q[c]  <= PW'(hs_q) * PW'(MW'(qd[c]) + (MW'(1) << FRACTION_BITS));
        prl_q[c]  <= PW'(ls_q) * PW'(MW'(qd[c]) + (MW'(1) << FRACTION_BITS));
      end
    end
  end

  // stage X: bounds, classify
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= '0;
    end else if (advance) begin
      x_q <= m_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      for (int c = 0; c < NCHAN; c++) begin
        upr_q[c] <= BW'(mean_q[c]) + BW'(prh_q[c]);
        lwr_q[c] <= BW'(mean_q[c]) - BW'(prl_q[c]);
      end
      upr_rd_q  <= upr_mem[m_addr];
      lwr_rd_q  <= lwr_mem[m_addr];
      upr_byp_q <= upr_q;
      lwr_byp_q <= lwr_q;
    end
  end

  assign bld_wr = advance && x_q.valid && (x_q.op == OP_BUILD) && x_q.rng;

  always_ff @(posedge clk_i) begin
    if (bld_wr) begin
      upr_mem[x_addr] <= upr_q;
      lwr_mem[x_addr] <= lwr_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bfwd_q <= 1'b0;
    end else if (advance) begin
      bfwd_q <= bld_wr && (x_q.pix == m_q.pix);
    end
  end

  always_comb begin
    upr_cur = bfwd_q ? upr_byp_q : upr_rd_q;
    lwr_cur = bfwd_q ? lwr_byp_q : lwr_rd_q;
    hit     = 1'b0;
    for (int c = 0; c < NCHAN; c++) begin
      if (($signed(BW'(x_q.chan[c]) << FRACTION_BITS) >= $signed(lwr_cur[c])) &&
          ($signed(BW'(x_q.chan[c]) << FRACTION_BITS) < $signed(upr_cur[c]))) begin
        hit = 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= x_q.valid && (x_q.op == OP_CLASSIFY);
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q.mask_out  <= x_q.rng && hit;
      out_q.index_out <= x_q.pix;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `BAM_ASSERT(a_frames_bound, frames_q <= NW'(MAX_LEARN_FRAMES), "frame count past bound")
  `BAM_ASSERT(a_count_after_first, (frames_q != '0) |-> first_q, "frames counted before first")
  `BAM_ASSERT(a_idle_in_clear, clr_busy_q |-> !p1_q.valid, "transaction during clear")
  `BAM_ASSERT_NEXT(a_out_only_classify, advance && !(x_q.valid && x_q.op == OP_CLASSIFY), !out_valid_q, "result without classify")

endmodule

// File: hdl/bam_div.sv
module bam_div #(
  parameter int DW = 17,
  parameter int NW = 6
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [DW-1:0] x_i,
  input  logic [NW-1:0] n_i,
  output logic [DW-1:0] q_o
);

  // restoring divider, one quotient bit per stage
  logic [NW-1:0] rem_q [DW];
  logic [DW-1:0] wrd_q [DW];
  logic [NW-1:0] dvs_q [DW];
  logic [NW-1:0] rem_d [DW];
  logic [DW-1:0] wrd_d [DW];
  logic [NW-1:0] dvs_d [DW];

  for (genvar k = 0; k < DW; k++) begin : g_stage
    logic [NW-1:0] rem_p;
    logic [DW-1:0] wrd_p;
    logic [NW:0]   trial;
    logic [NW:0]   diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_p    = '0;
      assign wrd_p    = x_i;
      assign dvs_d[k] = n_i;
    end else begin : g_next
      assign rem_p    = rem_q[k-1];
      assign wrd_p    = wrd_q[k-1];
      assign dvs_d[k] = dvs_q[k-1];
    end

    always_comb begin
      trial    = {rem_p, wrd_p[DW-1]};
      diff     = trial - {1'b0, dvs_d[k]};
      ge       = trial >= {1'b0, dvs_d[k]};
      rem_d[k] = ge ? diff[NW-1:0] : trial[NW-1:0];
      wrd_d[k] = {wrd_p[DW-2:0], ge};
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= rem_d[k];
        wrd_q[k] <= wrd_d[k];
        dvs_q[k] <= dvs_d[k];
      end
    end
  end

  assign q_o = wrd_q[DW-1];

endmodule
